// ===== rtl/msbd_pkg.sv =====
// ----------------------------------------------------------------------------
// msbd_pkg
// Shared types, constants and helpers for the mono spectrum bar display.
// ----------------------------------------------------------------------------
package msbd_pkg;

    localparam int BANDS_DEF = 8;
    localparam int ROWS_DEF  = 8;

    localparam int IDX_W   = 3;
    localparam int MAG_W   = 16;
    localparam int LVL_W   = 14;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 3;
    localparam int HUE_W   = 8;
    localparam int BRT_W   = 8;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 24;

    localparam logic [LVL_W-1:0] LVL_RESET    = 14'd300;
    localparam logic [LVL_W-1:0] LVL_TOP_KNEE = 14'd9800;
    localparam logic [LVL_W-1:0] LVL_TOP      = 14'd10000;
    localparam logic [LVL_W-1:0] LVL_UP       = 14'd200;
    localparam logic [LVL_W-1:0] LVL_DOWN     = 14'd100;
    localparam logic [LVL_W-1:0] LVL_LOW_KNEE = 14'd400;
    localparam logic [LVL_W-1:0] LVL_FLOOR    = 14'd300;
    localparam logic [LVL_W-1:0] BAR_CLAMP    = 14'd9000;
    localparam logic [LVL_W-1:0] SEG_SIZE     = 14'd1500;
    localparam logic [BRT_W-1:0] BRT_FULL     = 8'd255;

    // 2^18 / 6, rounded up; exact floor for inputs below 2^17
    localparam logic [15:0] DIV6_RECIP = 16'd43691;

    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic [HUE_W-1:0] hue;
        logic [LVL_W-1:0] bar;
    } t_bar_cmd;

    function automatic logic [BRT_W-1:0] div6(input logic [10:0] x);
        logic [26:0] prod;
        prod = 27'(x) * 27'(DIV6_RECIP);
        return prod[25:18];
    endfunction

    // (colour + 25 * idx) mod 256
    function automatic logic [HUE_W-1:0] hue_of(input logic [HUE_W-1:0] colour,
                                                input logic [IDX_W-1:0] idx);
        logic [HUE_W-1:0] step;
        step = {1'b0, idx, 4'b0} + {2'b0, idx, 3'b0} + {5'b0, idx};
        return colour + step;
    endfunction

    function automatic logic [LVL_W-1:0] level_step(input logic [LVL_W-1:0] lvl,
                                                    input logic [MAG_W-1:0] target);
        logic [LVL_W-1:0] res;
        res = lvl;
        if (target > MAG_W'(lvl)) begin
            res = (lvl < LVL_TOP_KNEE) ? lvl + LVL_UP : LVL_TOP;
        end else if (target < MAG_W'(lvl)) begin
            res = (lvl > LVL_LOW_KNEE) ? lvl - LVL_DOWN : LVL_FLOOR;
        end
        return res;
    endfunction

endpackage

// ===== rtl/msbd_level_mem.sv =====
// ----------------------------------------------------------------------------
// msbd_level_mem
// Per-band level store: synchronous RAM with registered read, valid bits so an
// unwritten band reads as the reset level.
// ----------------------------------------------------------------------------
module msbd_level_mem #(
    parameter int BANDS = msbd_pkg::BANDS_DEF,
    parameter int AW    = (BANDS > 1) ? $clog2(BANDS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [msbd_pkg::LVL_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [msbd_pkg::LVL_W-1:0] i_wr_data
);

    logic [msbd_pkg::LVL_W-1:0] r_mem [BANDS];
    logic [BANDS-1:0]           r_vld;
    logic [msbd_pkg::LVL_W-1:0] r_q;
    logic                       r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q     <= r_mem[i_rd_addr];
            r_q_vld <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_q_vld ? r_q : msbd_pkg::LVL_RESET;

endmodule

// ===== rtl/msbd_bar_seq.sv =====
// ----------------------------------------------------------------------------
// msbd_bar_seq
// Bar sequencer: walks one bar up from row 0, one LED per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module msbd_bar_seq #(
    parameter int ROWS = msbd_pkg::ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  msbd_pkg::t_bar_cmd               i_cmd,
    output logic                             o_busy,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [msbd_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                             o_m_tlast
);

    localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);

    logic                         r_active;
    logic [msbd_pkg::LVL_W-1:0]   r_rem;
    logic [msbd_pkg::ROW_W-1:0]   r_row;
    logic [msbd_pkg::IDX_W-1:0]   r_col;
    logic [msbd_pkg::HUE_W-1:0]   r_hue;

    logic                         r_tvalid;
    logic [msbd_pkg::IDX_W-1:0]   r_o_col;
    logic [msbd_pkg::ROW_W-1:0]   r_o_row;
    logic [msbd_pkg::HUE_W-1:0]   r_o_hue;
    logic [msbd_pkg::BRT_W-1:0]   r_o_brt;
    logic                         r_o_last;

    logic                         w_load;
    logic                         w_full;
    logic                         w_last;
    logic [msbd_pkg::BRT_W-1:0]   w_brt;

    assign w_load = r_active && (!r_tvalid || i_m_tready);
    assign w_full = r_rem > msbd_pkg::SEG_SIZE;
    // rows past the panel are dropped, so the top visible row closes the bar
    assign w_last = !w_full || ({2'b0, r_row} == LAST_ROW);
    assign w_brt  = w_full ? msbd_pkg::BRT_FULL : msbd_pkg::div6(r_rem[10:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            if (i_start) begin
                r_active <= 1'b1;
            end else if (w_load && w_last) begin
                r_active <= 1'b0;
            end
            if (w_load) begin
                r_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_cmd.bar;
            r_row <= '0;
            r_col <= i_cmd.col;
            r_hue <= i_cmd.hue;
        end else if (w_load) begin
            r_rem <= r_rem - msbd_pkg::SEG_SIZE;
            r_row <= r_row + 3'd1;
        end
        if (w_load) begin
            r_o_col  <= r_col;
            r_o_row  <= r_row;
            r_o_hue  <= r_hue;
            r_o_brt  <= w_brt;
            r_o_last <= w_last;
        end
    end

    assign o_busy     = r_active;
    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = {2'b00, r_o_brt, r_o_hue, r_o_row, r_o_col};
    assign o_m_tlast  = r_o_last;

endmodule

// ===== rtl/mono_spectrum_bar_display_unit.sv =====
// ----------------------------------------------------------------------------
// mono_spectrum_bar_display_unit
// Spectrum bar display: per-band level tracking and LED bar generation.
// ----------------------------------------------------------------------------
// Input stream carries one band per request: band index, left/right band
// magnitudes and the frame's left/right amplitudes. Output stream carries one
// LED per request (column, row, hue, brightness); tlast marks the top LED of
// a band's bar. Every in-range band yields 1 to 6 LEDs.
// Flow: a request is taken in the idle state; the band level is read from
// the level RAM in that cycle, stepped and written back in the next cycle,
// then the bar sequencer emits one LED per cycle while the receiver does not
// stall. The first LED passes through the CALC state and the sequencer's
// active flag into its output register. A band index at or above BANDS
// only steps the colour level (at index 0) and stays in idle.
// Reset clears the colour level to zero; every band reads 300 until written.
// When the receiver stalls, the last LED is held in the output register and
// the sequencer waits; the next band request is taken only after the current
// bar's final LED has been loaded into the output register.
// ----------------------------------------------------------------------------
module mono_spectrum_bar_display_unit #(
    parameter int BANDS = msbd_pkg::BANDS_DEF,
    parameter int ROWS  = msbd_pkg::ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // band_index, band_left, band_right, amp_left, amp_right, zero pad
    input  logic [msbd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // column, row, hue, brightness, zero pad
    output logic [msbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);

    localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [msbd_pkg::COL_W-1:0]   r_colour, n_colour;
    logic [msbd_pkg::IDX_W-1:0]   r_idx;
    logic [msbd_pkg::MAG_W-1:0]   r_target;

    logic                         w_accept;
    logic [msbd_pkg::IDX_W-1:0]   w_idx;
    logic [msbd_pkg::MAG_W-1:0]   w_bl, w_br, w_al, w_ar;
    logic [msbd_pkg::MAG_W:0]     w_band_sum, w_amp_sum;
    logic [msbd_pkg::COL_W-1:0]   w_colour_tgt;
    logic                         w_in_range;
    logic [AW+msbd_pkg::IDX_W-1:0] w_idx_ext, w_ridx_ext;
    logic [AW-1:0]                w_rd_addr, w_wr_addr;
    logic [msbd_pkg::LVL_W-1:0]   w_lvl_old, w_lvl_new;
    logic                         w_start;
    msbd_pkg::t_bar_cmd           w_cmd;
    logic                         w_busy;

    assign w_idx = s_axis_tdata[2:0];
    assign w_bl  = s_axis_tdata[18:3];
    assign w_br  = s_axis_tdata[34:19];
    assign w_al  = s_axis_tdata[50:35];
    assign w_ar  = s_axis_tdata[66:51];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_range    = {2'b00, w_idx} < 5'(BANDS);

    assign w_band_sum   = {1'b0, w_bl} + {1'b0, w_br};
    assign w_amp_sum    = {1'b0, w_al} + {1'b0, w_ar};
    // mean amplitude >> 4
    assign w_colour_tgt = w_amp_sum[msbd_pkg::MAG_W:5];

    assign w_idx_ext  = {{AW{1'b0}}, w_idx};
    assign w_ridx_ext = {{AW{1'b0}}, r_idx};
    assign w_rd_addr  = w_idx_ext[AW-1:0];
    assign w_wr_addr  = w_ridx_ext[AW-1:0];

    always_comb begin
        n_colour = r_colour;
        if (w_accept && (w_idx == '0)) begin
            if (w_colour_tgt > r_colour) begin
                n_colour = r_colour + 12'd1;
            end else if (w_colour_tgt < r_colour) begin
                n_colour = r_colour - 12'd1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_in_range) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: n_state = ST_WAIT;
            ST_WAIT: begin
                if (!w_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_colour <= '0;
        end else begin
            r_state  <= n_state;
            r_colour <= n_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx    <= w_idx;
            r_target <= w_band_sum[msbd_pkg::MAG_W:1];
        end
    end

    assign w_start   = (r_state == ST_CALC);
    assign w_lvl_new = msbd_pkg::level_step(w_lvl_old, r_target);

    assign w_cmd.col = r_idx;
    assign w_cmd.hue = msbd_pkg::hue_of(r_colour[7:0], r_idx);
    assign w_cmd.bar = (w_lvl_new > msbd_pkg::BAR_CLAMP) ? msbd_pkg::BAR_CLAMP : w_lvl_new;

    msbd_level_mem #(
        .BANDS (BANDS),
        .AW    (AW)
    ) u_level_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept && w_in_range),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_lvl_old),
        .i_wr_en   (w_start),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_lvl_new)
    );

    msbd_bar_seq #(
        .ROWS (ROWS)
    ) u_bar_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_cmd      (w_cmd),
        .o_busy     (w_busy),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/msbd_checker.sv =====
// ----------------------------------------------------------------------------
// msbd_checker
// Port-level checks for the spectrum bar display, bound to the top level.
// ----------------------------------------------------------------------------
module msbd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [msbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // partial LED is always the top of the bar
    a_partial_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[21:14] != msbd_pkg::BRT_FULL) |-> m_axis_tlast)
        else $error("partial LED not marked last");

    // no new band while a bar is still being drawn
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready while bar still in progress");

endmodule

bind mono_spectrum_bar_display_unit msbd_checker u_msbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the spectrum bar display. Band requests are driven
// from a pending queue. Each accepted band is run through a local predictor
// of the level, colour and LED bar logic, and every LED request that comes out
// is checked field by field against the oldest predicted LED.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NBANDS         = 8;
    localparam int NROWS          = 8;
    localparam int MAX_LEDS       = 6;
    localparam int LEVEL_RESET    = 300;
    localparam int LEVEL_TOP_KNEE = 9800;
    localparam int LEVEL_TOP      = 10000;
    localparam int LEVEL_UP       = 200;
    localparam int LEVEL_DOWN     = 100;
    localparam int LEVEL_LOW_KNEE = 400;
    localparam int LEVEL_FLOOR    = 300;
    localparam int BAR_MAX        = 9000;
    localparam int SEGMENT        = 1500;
    localparam int HUE_STRIDE     = 25;
    localparam int PARTIAL_DIV    = 6;
    localparam int FULL_BRIGHT    = 255;
    localparam int MAG_MAX        = 65535;

    localparam int RANDOM_ITEMS = 260;
    localparam int TAIL_ITEMS   = 30;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 16;
    localparam int MAX_PRINTS   = 50;

    typedef struct packed {
        logic [15:0] amp_r;
        logic [15:0] amp_l;
        logic [15:0] mag_r;
        logic [15:0] mag_l;
        logic [2:0]  idx;
    } t_band_req;

    typedef struct packed {
        logic      hold;    // pause the feed until all LEDs are back
        t_band_req req;
    } t_band_slot;

    typedef struct packed {
        logic       last;
        logic [7:0] brt;
        logic [7:0] hue;
        logic [2:0] row;
        logic [2:0] col;
    } t_led;

    typedef struct packed {
        logic [NBANDS-1:0][13:0] lvl;
        logic [11:0]             colour;
    } t_shown;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // band_index, band_left, band_right, amp_left, amp_right, zero pad
    logic [msbd_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // column, row, hue, brightness, zero pad
    logic [msbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    t_band_slot band_queue[$];
    t_led       leds_due[$];
    t_shown     plan_st;
    t_shown     bar_st;
    int         errors = 0;
    int         cycles = 0;
    int         feed_gap = 0;
    int         sink_stall = 0;
    logic       in_taken = 1'b0;
    t_band_slot nxt;
    t_band_req  seen_req;
    t_led [MAX_LEDS-1:0] seen_leds;
    int         seen_n;
    t_led       got_led;
    t_led       want_led;

    mono_spectrum_bar_display_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_shown shown_reset();
        t_shown st;
        for (int b = 0; b < NBANDS; b++) begin
            st.lvl[b] = 14'(LEVEL_RESET);
        end
        st.colour = '0;
        return st;
    endfunction

    // Steps colour and band level, then lays out the LEDs of the bar.
    function automatic int draw_band(inout t_shown st, input t_band_req req,
                                     output t_led [MAX_LEDS-1:0] leds);
        int ct;
        int target;
        int lvl;
        int bar;
        int row;
        int n;
        logic [7:0] hue;
        leds = '0;
        n = 0;
        if (req.idx == 3'd0) begin
            ct = ((int'(req.amp_l) + int'(req.amp_r)) / 2) >> 4;
            if (ct > int'(st.colour)) begin
                st.colour = st.colour + 12'd1;
            end else if (ct < int'(st.colour)) begin
                st.colour = st.colour - 12'd1;
            end
        end
        if (int'(req.idx) >= NBANDS) return 0;
        target = (int'(req.mag_l) + int'(req.mag_r)) / 2;
        lvl = int'(st.lvl[req.idx]);
        if (target > lvl) begin
            lvl = (lvl < LEVEL_TOP_KNEE) ? lvl + LEVEL_UP : LEVEL_TOP;
        end else if (target < lvl) begin
            lvl = (lvl > LEVEL_LOW_KNEE) ? lvl - LEVEL_DOWN : LEVEL_FLOOR;
        end
        st.lvl[req.idx] = 14'(lvl);
        bar = (lvl > BAR_MAX) ? BAR_MAX : lvl;
        hue = 8'(int'(st.colour) + HUE_STRIDE * int'(req.idx));
        row = 0;
        while (bar > SEGMENT) begin
            if (row < NROWS) begin
                leds[n] = {1'b0, 8'(FULL_BRIGHT), hue, 3'(row), req.idx};
                n++;
            end
            row++;
            bar -= SEGMENT;
        end
        if (row < NROWS) begin
            leds[n] = {1'b0, 8'(bar / PARTIAL_DIV), hue, 3'(row), req.idx};
            n++;
        end
        if (n > 0) leds[n-1].last = 1'b1;
        return n;
    endfunction

    task automatic add_band(input int idx, input int ml, input int mr,
                            input int al, input int ar);
        t_band_slot slot;
        t_led [MAX_LEDS-1:0] scratch;
        slot.hold      = 1'b0;
        slot.req.idx   = 3'(idx);
        slot.req.mag_l = 16'(ml);
        slot.req.mag_r = 16'(mr);
        slot.req.amp_l = 16'(al);
        slot.req.amp_r = 16'(ar);
        void'(draw_band(plan_st, slot.req, scratch));
        band_queue.push_back(slot);
    endtask

    // Splits a target band level into a left/right pair whose mean is exact.
    task automatic add_target(input int idx, input int t, input int al, input int ar);
        int odd;
        int span;
        int d;
        odd = (t < MAG_MAX) ? $urandom_range(0, 1) : 0;
        span = (t < MAG_MAX - t - odd) ? t : MAG_MAX - t - odd;
        d = $urandom_range(0, span);
        add_band(idx, t - d, t + d + odd, al, ar);
    endtask

    task automatic add_hold();
        t_band_slot slot;
        slot = '0;
        slot.hold = 1'b1;
        band_queue.push_back(slot);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("[%0t] LED mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    // Band request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (in_taken || !s_axis_tvalid) begin
            if (feed_gap > 0) begin
                feed_gap = feed_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (band_queue.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (band_queue[0].hold) begin
                s_axis_tvalid <= 1'b0;
                if (leds_due.size() == 0) void'(band_queue.pop_front());
            end else if (band_queue.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
                feed_gap = $urandom_range(0, 3);
                s_axis_tvalid <= 1'b0;
            end else begin
                nxt = band_queue.pop_front();
                s_axis_tdata  <= msbd_pkg::IN_TDATA_W'(nxt.req);
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // LED sink backpressure
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall = sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (band_queue.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
            sink_stall = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Predict on accepted bands, check accepted LEDs
    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            cycles = cycles + 1;
            if (s_axis_tvalid && s_axis_tready) begin
                seen_req = t_band_req'(s_axis_tdata[$bits(t_band_req)-1:0]);
                seen_n = draw_band(bar_st, seen_req, seen_leds);
                for (int k = 0; k < seen_n; k++) leds_due.push_back(seen_leds[k]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_led = {m_axis_tlast, m_axis_tdata[21:0]};
                if (leds_due.size() == 0) begin
                    report_mismatch("unexpected LED (packed)", int'(got_led), 0);
                end else begin
                    want_led = leds_due.pop_front();
                    if (got_led.col != want_led.col)
                        report_mismatch("column", int'(got_led.col), int'(want_led.col));
                    if (got_led.row != want_led.row)
                        report_mismatch("row", int'(got_led.row), int'(want_led.row));
                    if (got_led.hue != want_led.hue)
                        report_mismatch("hue", int'(got_led.hue), int'(want_led.hue));
                    if (got_led.brt != want_led.brt)
                        report_mismatch("brightness", int'(got_led.brt), int'(want_led.brt));
                    if (got_led.last != want_led.last)
                        report_mismatch("last", int'(got_led.last), int'(want_led.last));
                end
            end
            if (cycles >= CYCLE_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        int made;
        int held;
        int len;
        int band;
        int lvl;
        int t;
        int al;
        int ar;
        logic up;
        logic [NBANDS-1:0] rising;

        plan_st = shown_reset();
        bar_st  = shown_reset();

        // Directed: all-zero and all-ones fields, colour up/hold/down
        add_band(0, 0, 0, 0, 0);
        add_band(0, MAG_MAX, MAG_MAX, MAG_MAX, MAG_MAX);
        for (int i = 1; i < NBANDS; i++) begin
            if (i % 2) add_band(i, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
            else       add_band(i, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        end
        // level equal to target, with even and odd sums
        lvl = int'(plan_st.lvl[3]);
        add_band(3, lvl, lvl, 0, 0);
        add_band(3, lvl, lvl + 1, 0, 0);
        // walk down through the low knee onto the floor
        while (int'(plan_st.lvl[2]) < 700) add_target(2, MAG_MAX, 0, 0);
        while (int'(plan_st.lvl[2]) > LEVEL_FLOOR) add_target(2, 0, 0, 0);
        add_band(0, 0, 0, 0, 0);
        add_hold();

        // Random: mostly whole frames, plus single-band runs and noise
        made = 0;
        held = 0;
        rising = NBANDS'($urandom);
        while (made < RANDOM_ITEMS) begin
            if (made == 0) begin
                // first run climbs one band all the way past the top knee
                band = $urandom_range(0, NBANDS - 1);
                len = $urandom_range(50, 56);
                up = 1'b1;
                t = 0;
            end else begin
                t = $urandom_range(0, 19);
            end
            if (made == 0 || t < 3) begin
                if (made != 0) begin
                    band = $urandom_range(0, NBANDS - 1);
                    up = $urandom_range(0, 1);
                    len = $urandom_range(10, up ? 56 : 40);
                end
                for (int k = 0; k < len; k++) begin
                    lvl = int'(plan_st.lvl[band]);
                    if (up) add_target(band, $urandom_range(lvl + 1, MAG_MAX),
                                       $urandom_range(0, MAG_MAX), $urandom_range(0, MAG_MAX));
                    else    add_target(band, $urandom_range(0, lvl - 1),
                                       $urandom_range(0, MAG_MAX), $urandom_range(0, MAG_MAX));
                end
                made += len;
            end else if (t < 7) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    add_band($urandom_range(0, 7), $urandom_range(0, MAG_MAX),
                             $urandom_range(0, MAG_MAX), $urandom_range(0, MAG_MAX),
                             $urandom_range(0, MAG_MAX));
                end
                made += len;
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    // amplitudes whose mean matches the colour level exactly
                    al = int'(plan_st.colour) << 4;
                    ar = al;
                end else begin
                    al = $urandom_range(0, MAG_MAX);
                    ar = $urandom_range(0, MAG_MAX);
                end
                for (int b = 0; b < NBANDS; b++) begin
                    if ($urandom_range(0, 5) == 0) rising[b] = ~rising[b];
                    lvl = int'(plan_st.lvl[b]);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: begin
                            if (rising[b]) t = $urandom_range(lvl + 1, MAG_MAX);
                            else           t = $urandom_range(0, lvl - 1);
                        end
                        6:       t = lvl;
                        default: t = $urandom_range(0, MAG_MAX);
                    endcase
                    add_target(b, t, al, ar);
                end
                made += NBANDS;
            end
            if (held == 0 && made >= RANDOM_ITEMS / 2) begin
                add_hold();
                held = 1;
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (band_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (leds_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
